// ===== rtl/core/multi_stack_shared_buffer_unit_assert.svh =====
// Assertion macros used by the checker of the multi-stack shared buffer.
// Needs nothing else; include it with the bare file name.
`ifndef MULTI_STACK_SHARED_BUFFER_UNIT_ASSERT_SVH
`define MULTI_STACK_SHARED_BUFFER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define MSBU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("msbu check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define MSBU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("msbu check failed");

`endif

// ===== rtl/core/msbu_pkg.sv =====
// Shared types, sizes and codes of the multi-stack shared buffer.
// Used by the controller, the datapath, the top level and the checker.
package msbu_pkg;

  localparam int NUM_STACKS = 4;
  localparam int NUM_SLOTS  = 64;
  localparam int SEL_W      = 2;
  localparam int DATA_W     = 32;
  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam int PTR_W      = $clog2(NUM_SLOTS + 1);

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [SLOT_W-1:0] slot_t;

  // The null link is the pointer value one past the last slot.
  localparam ptr_t NULL_PTR = PTR_W'(NUM_SLOTS);

  typedef enum logic {
    MODE_PUSH = 1'b0,
    MODE_POP  = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // request accepted: capture it and read the memories
    logic exec;  // update pointers, write the memories, form the result
  } cmd_t;

  function automatic logic ptr_valid(ptr_t p);
    return p < NULL_PTR;
  endfunction

endpackage

// ===== rtl/core/msbu_ctrl.sv =====
// Controller of the multi-stack shared buffer: two-state sequencer.
// Depends on msbu_pkg for the state and command types.
module msbu_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  output msbu_pkg::cmd_t cmd,
  output logic           out_valid
);
  import msbu_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state: a request moves to execute, execute always returns to idle.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Outputs decoded from the current state.
  always_comb begin
    busy     = 1'b0;
    cmd.load = 1'b0;
    cmd.exec = 1'b0;
    case (state_r)
      S_IDLE: begin
        cmd.load = start;
      end
      S_EXEC: begin
        busy     = 1'b1;
        cmd.exec = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // The result strobe is registered from the execute command, so it rises in the cycle after execute.
  assign out_valid_nxt = cmd.exec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/msbu_dpath.sv =====
// Datapath of the multi-stack shared buffer: value and link memories,
// stack top pointers, free-list head and the result register.
// Depends on msbu_pkg; driven by commands from msbu_ctrl.
module msbu_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  msbu_pkg::cmd_t                      cmd,
  input  logic                                in_mode,
  input  logic [msbu_pkg::SEL_W-1:0]          in_stack_sel,
  input  logic signed [msbu_pkg::DATA_W-1:0]  in_push_value,
  output logic [1:0]                          out_status,
  output logic signed [msbu_pkg::DATA_W-1:0]  out_pop_value
);
  import msbu_pkg::*;

  // Captured request.
  logic                     mode_r;
  logic [SEL_W-1:0]         sel_r;
  logic signed [DATA_W-1:0] val_r;

  // Pointer state.
  ptr_t stack_top_r   [NUM_STACKS];
  ptr_t stack_top_nxt [NUM_STACKS];
  ptr_t free_head_r, free_head_nxt;

  // Memories; link entries not yet written read as their reset link.
  ptr_t                     link_mem [NUM_SLOTS];
  logic [DATA_W-1:0]        val_mem  [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]     link_vld_r;
  ptr_t                     link_rd_r;
  logic [DATA_W-1:0]        val_rd_r;
  slot_t                    rd_addr_r;
  logic                     link_vld_rd_r;

  // Result register.
  status_t                  status_r, status_nxt;
  logic signed [DATA_W-1:0] pop_value_r, pop_value_nxt;

  // Read side, evaluated on the incoming request.
  logic  sel_in_ok;
  ptr_t  rd_ptr;
  slot_t rd_addr;

  // Execute side, evaluated on the captured request.
  logic  sel_ok;
  logic  is_pop;
  ptr_t  cur_top;
  ptr_t  op_ptr;
  logic  op_ok;
  slot_t op_slot;
  ptr_t  link_cur;
  ptr_t  link_wr;

  // Read address: top of the addressed stack for a pop, free head for a push.
  always_comb begin
    sel_in_ok = int'(in_stack_sel) < NUM_STACKS;
    if (in_mode == MODE_POP) begin
      rd_ptr = sel_in_ok ? stack_top_r[in_stack_sel] : NULL_PTR;
    end else begin
      rd_ptr = free_head_r;
    end
    rd_addr = rd_ptr[SLOT_W-1:0];
  end

  // Capture the request and read both memories at the same slot.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r        <= in_mode;
      sel_r         <= in_stack_sel;
      val_r         <= in_push_value;
      rd_addr_r     <= rd_addr;
      link_rd_r     <= link_mem[rd_addr];
      val_rd_r      <= val_mem[rd_addr];
      link_vld_rd_r <= link_vld_r[rd_addr];
    end
  end

  // Link as it stands in the store: slot i links i+1 until first written.
  assign link_cur = link_vld_rd_r ? link_rd_r : (PTR_W'(rd_addr_r) + PTR_W'(1));

  // Execute: decide the outcome and the new pointers.
  always_comb begin
    sel_ok  = int'(sel_r) < NUM_STACKS;
    is_pop  = (mode_r == MODE_POP);
    cur_top = sel_ok ? stack_top_r[sel_r] : NULL_PTR;
    op_ptr  = is_pop ? cur_top : free_head_r;
    op_ok   = sel_ok && ptr_valid(op_ptr);
    op_slot = op_ptr[SLOT_W-1:0];
    link_wr = is_pop ? free_head_r : cur_top;

    for (int i = 0; i < NUM_STACKS; i++) begin
      stack_top_nxt[i] = stack_top_r[i];
    end
    free_head_nxt = free_head_r;
    pop_value_nxt = '0;

    if (op_ok) begin
      status_nxt = ST_OK;
      if (is_pop) begin
        stack_top_nxt[sel_r] = link_cur;
        free_head_nxt        = op_ptr;
        pop_value_nxt        = val_rd_r;
      end else begin
        stack_top_nxt[sel_r] = op_ptr;
        free_head_nxt        = link_cur;
      end
    end else begin
      status_nxt = is_pop ? ST_UNDERFLOW : ST_OVERFLOW;
    end
  end

  // Pointer registers and link valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        stack_top_r[i] <= NULL_PTR;
      end
      free_head_r <= '0;
      link_vld_r  <= '0;
    end else if (cmd.exec) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        stack_top_r[i] <= stack_top_nxt[i];
      end
      free_head_r <= free_head_nxt;
      if (op_ok) link_vld_r[op_slot] <= 1'b1;
    end
  end

  // Memory writes: the link on every successful request, the value on a successful push.
  always_ff @(posedge clk) begin
    if (cmd.exec && op_ok) begin
      link_mem[op_slot] <= link_wr;
      if (!is_pop) val_mem[op_slot] <= val_r;
    end
  end

  // Result register, loaded at the end of the execute cycle.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r    <= status_nxt;
      pop_value_r <= pop_value_nxt;
    end
  end

  assign out_status    = status_r;
  assign out_pop_value = pop_value_r;

endmodule

// ===== rtl/core/multi_stack_shared_buffer_unit.sv =====
// Multi-stack shared buffer: four LIFO stacks of 32-bit values sharing 64
// slots, with free slots kept on a linked list. A request is taken when start
// is high and busy is low; busy then stays high for one cycle. A request has a
// load step, the registered read of the link memory, which must finish before
// the execute step can update the pointers. Every request gives exactly one
// result, shown for a single cycle with out_valid, which is registered from the
// execute step; the result is taken at the second edge after the request edge,
// and the receiver cannot stall it, so it must take it then.
// Status 0 is success, 1 is overflow on a push with no free slot and 2 is
// underflow on a pop from an empty stack; out_pop_value is zero unless a pop
// succeeded. No clearing pass is needed after reset.
// Depends on msbu_pkg, msbu_ctrl and msbu_dpath.
module multi_stack_shared_buffer_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_mode,
  input  logic [msbu_pkg::SEL_W-1:0]          in_stack_sel,
  input  logic signed [msbu_pkg::DATA_W-1:0]  in_push_value,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic signed [msbu_pkg::DATA_W-1:0]  out_pop_value
);
  import msbu_pkg::*;

  cmd_t cmd;

  // Sequencer.
  msbu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  // Storage and pointer logic.
  msbu_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_mode       (in_mode),
    .in_stack_sel  (in_stack_sel),
    .in_push_value (in_push_value),
    .out_status    (out_status),
    .out_pop_value (out_pop_value)
  );

endmodule

// ===== rtl/core/msbu_checker.sv =====
// Port-level checker of the multi-stack shared buffer, bound to the top level.
// Depends on msbu_pkg and multi_stack_shared_buffer_unit_assert.svh.
`include "multi_stack_shared_buffer_unit_assert.svh"

module msbu_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic                                out_valid,
  input logic [1:0]                          out_status,
  input logic signed [msbu_pkg::DATA_W-1:0]  out_pop_value
);
  import msbu_pkg::*;

  logic req_acc;
  assign req_acc = start && !busy;

  // An accepted request keeps the block busy for the following cycle.
  `MSBU_ASSERT_NEXT(a_acc_busy, clk, rst_n, req_acc, busy)

  // Busy lasts a single cycle per request.
  `MSBU_ASSERT_NEXT(a_busy_one, clk, rst_n, busy, !busy)

  // Every result traces back to an accepted request, through the execute state and the strobe register.
  `MSBU_ASSERT_NOW(a_res_src, clk, rst_n, out_valid, $past(req_acc, 2))

  // A failed request returns a zero value.
  `MSBU_ASSERT_NOW(a_fail_zero, clk, rst_n, out_valid && (out_status != ST_OK), out_pop_value == '0)

endmodule

bind multi_stack_shared_buffer_unit msbu_checker u_msbu_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the multi-stack shared buffer unit.
// Depends on msbu_pkg and multi_stack_shared_buffer_unit; the latter needs msbu_ctrl and msbu_dpath.
module tb;
  import msbu_pkg::*;

  // One reply as the block reports it.
  typedef struct {
    status_t            status;
    logic signed [31:0] value;
  } stack_reply_t;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic                       in_mode;
  logic [SEL_W-1:0]           in_stack_sel;
  logic signed [DATA_W-1:0]   in_push_value;
  logic                       out_valid;
  logic [1:0]                 out_status;
  logic signed [DATA_W-1:0]   out_pop_value;

  // Replies still to come, oldest first.
  stack_reply_t reply_q[$];

  // Shadow copy of the shared store, its links and the list heads.
  logic [DATA_W-1:0] slot_value [NUM_SLOTS];
  ptr_t              slot_link  [NUM_SLOTS];
  ptr_t              top_ptr    [NUM_STACKS];
  ptr_t              free_ptr;
  int                slots_used;

  int  mismatches;
  int  requests_sent;
  bit  no_gaps;

  multi_stack_shared_buffer_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_stack_sel  (in_stack_sel),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_pop_value (out_pop_value)
  );

  // Clock with a 4 ns period.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2000000;
    $display("multi_stack_shared_buffer_unit: mismatch");
    $finish;
  end

  // Puts the shadow state in its reset condition: every slot free, every stack empty.
  function automatic void clear_stacks();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_value[i] = '0;
      slot_link[i]  = ptr_t'(i + 1);
    end
    for (int i = 0; i < NUM_STACKS; i++) begin
      top_ptr[i] = NULL_PTR;
    end
    free_ptr   = '0;
    slots_used = 0;
  endfunction

  // Applies one accepted request to the shadow state and queues the reply it gives.
  function automatic void apply_stack_op(mode_t m, logic [SEL_W-1:0] sel,
                                         logic signed [DATA_W-1:0] v);
    stack_reply_t r;
    ptr_t         s;
    r.status = ST_OK;
    r.value  = '0;
    if (m == MODE_PUSH) begin
      s = free_ptr;
      if (int'(sel) >= NUM_STACKS || s >= NULL_PTR) begin
        r.status = ST_OVERFLOW;
      end else begin
        free_ptr                  = slot_link[s[SLOT_W-1:0]];
        slot_value[s[SLOT_W-1:0]] = v;
        slot_link[s[SLOT_W-1:0]]  = top_ptr[sel];
        top_ptr[sel]              = s;
        slots_used++;
      end
    end else begin
      if (int'(sel) >= NUM_STACKS) begin
        r.status = ST_UNDERFLOW;
      end else begin
        s = top_ptr[sel];
        if (s >= NULL_PTR) begin
          r.status = ST_UNDERFLOW;
        end else begin
          top_ptr[sel]             = slot_link[s[SLOT_W-1:0]];
          r.value                  = slot_value[s[SLOT_W-1:0]];
          slot_link[s[SLOT_W-1:0]] = free_ptr;
          free_ptr                 = s;
          slots_used--;
        end
      end
    end
    reply_q.push_back(r);
  endfunction

  // Counts a failure and reports the first few of them.
  function automatic void note_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s", $realtime, what);
    end
  endfunction

  // Random push value, leaning on the extremes now and then.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return -32'sd1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // Random stack number over the whole select range.
  function automatic logic [SEL_W-1:0] pick_stack();
    return SEL_W'($urandom_range(0, NUM_STACKS - 1));
  endfunction

  // Sends one request: an optional idle gap, then start held until the block takes it.
  task automatic send_request(input mode_t m, input logic [SEL_W-1:0] sel,
                              input logic signed [DATA_W-1:0] v);
    int gap;
    if (no_gaps) begin
      gap = 0;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
    end
    // While idle, the request fields carry noise that must be ignored.
    if (gap > 0) begin
      start         <= 1'b0;
      in_mode       <= 1'($urandom_range(0, 1));
      in_stack_sel  <= pick_stack();
      in_push_value <= $urandom;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_mode       <= m;
    in_stack_sel  <= sel;
    in_push_value <= v;
    do @(posedge clk); while (busy);
    apply_stack_op(m, sel, v);
    requests_sent++;
  endtask

  // Compares every reply with the oldest expected one.
  always @(posedge clk) begin
    stack_reply_t e;
    if (rst_n && out_valid) begin
      if (reply_q.size() == 0) begin
        note_mismatch($sformatf("unexpected reply status %0d value %0d",
                                out_status, out_pop_value));
      end else begin
        e = reply_q.pop_front();
        if (out_status !== e.status || out_pop_value !== e.value) begin
          note_mismatch($sformatf("reply: expected status %0d value %0d, got %0d %0d",
                                  e.status, e.value, out_status, out_pop_value));
        end
      end
    end
  end

  // Underflow on every empty stack, extreme values, the all-ones value popped back.
  task automatic test_directed();
    no_gaps = 1'b0;
    for (int i = 0; i < NUM_STACKS; i++) begin
      send_request(MODE_POP, SEL_W'(i), pick_value());
    end
    send_request(MODE_PUSH, 0, 32'sh8000_0000);
    send_request(MODE_PUSH, 1, 32'sh7FFF_FFFF);
    send_request(MODE_PUSH, 2, '0);
    send_request(MODE_PUSH, 3, -32'sd1);
    send_request(MODE_PUSH, 0, 32'sh5555_5555);
    send_request(MODE_PUSH, 0, 32'shAAAA_AAAA);
    send_request(MODE_POP,  3, 32'sh1234_5678);
    send_request(MODE_POP,  3, '0);
    send_request(MODE_POP,  0, '0);
    send_request(MODE_POP,  0, '0);
    send_request(MODE_POP,  0, '0);
    send_request(MODE_POP,  0, '0);
    send_request(MODE_POP,  1, '0);
    send_request(MODE_POP,  2, '0);
    send_request(MODE_POP,  2, '0);
  endtask

  // Fills the whole store past overflow, then drains every stack past underflow.
  task automatic test_fill_drain(input bit burst);
    int guard;
    no_gaps = burst;
    for (int i = 0; i < NUM_SLOTS + 6; i++) begin
      send_request(MODE_PUSH, pick_stack(), pick_value());
    end
    guard = 0;
    while (slots_used > 0 && guard < 4 * NUM_SLOTS) begin
      send_request(MODE_POP, pick_stack(), pick_value());
      guard++;
    end
    for (int i = 0; i < NUM_STACKS; i++) begin
      send_request(MODE_POP, SEL_W'(i), pick_value());
    end
  endtask

  // Phases of random requests, each with its own push bias and gap setting.
  task automatic test_random_mix(input int target);
    int phase_len;
    int push_pct;
    while (requests_sent < target) begin
      phase_len = $urandom_range(40, 160);
      case ($urandom_range(0, 2))
        0: push_pct = 15;
        1: push_pct = 50;
        default: push_pct = 85;
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < phase_len; i++) begin
        send_request(($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_POP,
                     pick_stack(), pick_value());
      end
    end
  endtask

  // Test sequence.
  initial begin
    mismatches    = 0;
    requests_sent = 0;
    no_gaps       = 1'b0;
    clear_stacks();
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_mode       <= MODE_PUSH;
    in_stack_sel  <= '0;
    in_push_value <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_fill_drain(1'b1);
    test_fill_drain(1'b0);
    test_random_mix(2000);

    // Drain the outstanding replies, then keep watching for stray ones before the verdict.
    start <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("multi_stack_shared_buffer_unit: match");
    end else begin
      $display("multi_stack_shared_buffer_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/msbu_pkg.sv
rtl/core/msbu_ctrl.sv
rtl/core/msbu_dpath.sv
rtl/core/multi_stack_shared_buffer_unit.sv
rtl/core/msbu_checker.sv
tb/tb.sv
